// ----- hdl/wpus_pkg.sv -----
// wpus_pkg: shared types and constants of the wildcard pattern scanner.
// Used by wpus_csr_if and every module of the block; depends on nothing.
package wpus_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 64;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PATTERN_BYTES  = 3'd0,
      CSR_CARE_MASK      = 3'd1,
      CSR_PATTERN_LENGTH = 3'd2,
      CSR_REGION_BASE    = 3'd3,
      CSR_RESULT_OFFSET  = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      MATCH_NONE = 2'd0,
      MATCH_ONE  = 2'd1,
      MATCH_MANY = 2'd2
   } match_class_type;

   typedef struct packed {
      logic [63:0] pattern_bytes;
      logic [7:0]  care_mask;
      logic [3:0]  eff_length;
      logic [15:0] region_base;
      logic [3:0]  result_offset;
   } cfg_type;

   typedef struct packed {
      logic        unique_found;
      logic [1:0]  match_class;
      logic [15:0] hit_address;
   } rsp_type;

endpackage

// ----- hdl/wpus_req_if.sv -----
// wpus_req_if: input byte channel of the scanner, valid/ready handshake.
// Standalone; no dependencies.
interface wpus_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, data_byte, last_byte, input ready);
   modport sink (input valid, data_byte, last_byte, output ready);
endinterface

// ----- hdl/wpus_rsp_if.sv -----
// wpus_rsp_if: page result channel of the scanner, valid/ready handshake.
// Standalone; no dependencies.
interface wpus_rsp_if;
   logic        valid;
   logic        ready;
   logic        unique_found;
   logic [1:0]  match_class;
   logic [15:0] hit_address;

   modport source (output valid, unique_found, match_class, hit_address, input ready);
   modport sink (input valid, unique_found, match_class, hit_address, output ready);
endinterface

// ----- hdl/wpus_csr_if.sv -----
// wpus_csr_if: register write channel of the scanner.
// Depends on wpus_pkg for the index and data widths.
interface wpus_csr_if
   import wpus_pkg::*;
();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ----- hdl/wpus_cfg_regs.sv -----
// wpus_cfg_regs: configuration registers with the clamped pattern length.
// Depends on wpus_pkg and wpus_csr_if.
module wpus_cfg_regs
   import wpus_pkg::*;
#(
   parameter int MAX_PATTERN = 8
) (
   input  logic       clock,
   input  logic       reset,
   wpus_csr_if.sink   csr,
   output cfg_type    cfg
);

   logic [63:0] pattern_ff, pattern_in;
   logic [7:0]  care_ff, care_in;
   logic [3:0]  length_ff, length_in;
   logic [15:0] base_ff, base_in;
   logic [3:0]  offset_ff, offset_in;
   logic        write;

   assign csr.ready = 1'b1;
   assign write     = csr.valid && csr.ready;

   always_comb begin
      pattern_in = pattern_ff;
      care_in    = care_ff;
      length_in  = length_ff;
      base_in    = base_ff;
      offset_in  = offset_ff;
      if (write) begin
         unique case (csr_index_type'(csr.index))
            CSR_PATTERN_BYTES:  pattern_in = csr.data;
            CSR_CARE_MASK:      care_in    = csr.data[7:0];
            CSR_PATTERN_LENGTH: length_in  = csr.data[3:0];
            CSR_REGION_BASE:    base_in    = csr.data[15:0];
            CSR_RESULT_OFFSET:  offset_in  = csr.data[3:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff <= '0;
         care_ff    <= 8'hFF;
         length_ff  <= 4'd1;
         base_ff    <= '0;
         offset_ff  <= '0;
      end else begin
         pattern_ff <= pattern_in;
         care_ff    <= care_in;
         length_ff  <= length_in;
         base_ff    <= base_in;
         offset_ff  <= offset_in;
      end
   end

   always_comb begin
      cfg.pattern_bytes = pattern_ff;
      cfg.care_mask     = care_ff;
      cfg.region_base   = base_ff;
      cfg.result_offset = offset_ff;
      priority if (length_ff == 4'd0) begin
         cfg.eff_length = 4'd1;
      end else if (length_ff > 4'(MAX_PATTERN)) begin
         cfg.eff_length = 4'(MAX_PATTERN);
      end else begin
         cfg.eff_length = length_ff;
      end
   end

endmodule

// ----- hdl/wpus_scan.sv -----
// wpus_scan: byte window, wildcard compare and per-page match tally.
// Produces the page result on the accepting edge's last byte; uses wpus_pkg.
module wpus_scan
   import wpus_pkg::*;
#(
   parameter int PAGE_BYTES  = 16384,
   parameter int MAX_PATTERN = 8
) (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       accept,
   input  logic [7:0] data_byte,
   input  logic       last_byte,
   output logic       done,
   output rsp_type    result
);

   localparam int POS_W = $clog2(PAGE_BYTES);
   localparam int WIN_W = 8 * MAX_PATTERN;

   logic [WIN_W-1:0]  window_ff, window_in, window_new;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [POS_W-1:0]  first_ff, first_in;
   match_class_type   tally_ff, tally_in;

   logic [POS_W:0]    taken;
   logic [POS_W:0]    len_ext;
   logic [POS_W-1:0]  first_cand;
   logic [MAX_PATTERN-1:0] miss;
   logic [7:0]        got [MAX_PATTERN];
   logic              hit;
   logic              page_end;
   match_class_type   tally_new;
   logic [POS_W-1:0]  first_new;

   assign window_new = WIN_W'({window_ff, data_byte});
   assign taken      = {1'b0, pos_ff} + (POS_W+1)'(1);
   assign len_ext    = (POS_W+1)'(cfg.eff_length);
   assign first_cand = POS_W'(taken - len_ext);

   // pattern byte k lines up with window byte eff_length-1-k
   always_comb begin
      for (int k = 0; k < MAX_PATTERN; k++) begin
         got[k] = '0;
         for (int j = 0; j < MAX_PATTERN; j++) begin
            if (4'(j + k + 1) == cfg.eff_length) begin
               got[k] = got[k] | window_new[8*j +: 8];
            end
         end
         miss[k] = cfg.care_mask[k] && (4'(k) < cfg.eff_length) &&
                   (cfg.pattern_bytes[8*k +: 8] != got[k]);
      end
   end

   assign hit      = (taken >= len_ext) && (miss == '0);
   assign page_end = last_byte || (taken == (POS_W+1)'(PAGE_BYTES));

   always_comb begin
      tally_new = tally_ff;
      first_new = first_ff;
      if (hit) begin
         unique case (tally_ff)
            MATCH_NONE: begin
               tally_new = MATCH_ONE;
               first_new = first_cand;
            end
            MATCH_ONE:  tally_new = MATCH_MANY;
            MATCH_MANY: tally_new = MATCH_MANY;
            default:    tally_new = MATCH_MANY;
         endcase
      end
   end

   always_comb begin
      window_in = window_ff;
      pos_in    = pos_ff;
      tally_in  = tally_ff;
      first_in  = first_ff;
      if (accept) begin
         if (page_end) begin
            window_in = '0;
            pos_in    = '0;
            tally_in  = MATCH_NONE;
            first_in  = '0;
         end else begin
            window_in = window_new;
            pos_in    = POS_W'(taken);
            tally_in  = tally_new;
            first_in  = first_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
         pos_ff    <= '0;
         tally_ff  <= MATCH_NONE;
         first_ff  <= '0;
      end else begin
         window_ff <= window_in;
         pos_ff    <= pos_in;
         tally_ff  <= tally_in;
         first_ff  <= first_in;
      end
   end

   assign done                = accept && page_end;
   assign result.unique_found = (tally_new == MATCH_ONE);
   assign result.match_class  = tally_new;
   assign result.hit_address  = (tally_new == MATCH_ONE) ?
      (cfg.region_base + 16'(first_new) + 16'(cfg.result_offset)) : 16'd0;

endmodule

// ----- hdl/wildcard_pattern_unique_scanner.sv -----
// wildcard_pattern_unique_scanner: top level of the wildcard byte scanner.
// Depends on wpus_pkg, the channel interfaces, wpus_cfg_regs and wpus_scan.
//
// Usage:
//   req: one page byte per item, last_byte marks the end of a page. A page
//        also ends on its PAGE_BYTES-th byte regardless of last_byte.
//   rsp: one item per page, sent after the page's final byte: the match
//        class (none, one, many), a unique flag and, when unique, the address
//        region_base + match start + result_offset (mod 2^16).
//   csr: register writes, always ready; write only while the block is idle.
// Throughput: one byte per cycle while req is ready; the window compare and
//   tally update sit between the page state and result registers.
// Result: registered, valid in the cycle after the final byte is taken.
// Stall: a waiting result is held in the output register; req stays ready
//   while that register is empty or being emptied in the same cycle.
// Reset: all registers take their reset values, the page state is cleared,
//   and no result is pending.
module wildcard_pattern_unique_scanner
   import wpus_pkg::*;
#(
   parameter int PAGE_BYTES  = 16384,
   parameter int MAX_PATTERN = 8
) (
   input  logic       clock,
   input  logic       reset,
   wpus_req_if.sink   req_bus,
   wpus_rsp_if.source rsp_bus,
   wpus_csr_if.sink   csr_bus
);

   cfg_type cfg;
   rsp_type result;
   rsp_type rsp_ff, rsp_in;
   logic    rsp_valid_ff, rsp_valid_in;
   logic    accept;
   logic    done;

   wpus_cfg_regs #(
      .MAX_PATTERN(MAX_PATTERN)
   ) u_cfg (
      .clock(clock),
      .reset(reset),
      .csr  (csr_bus),
      .cfg  (cfg)
   );

   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign accept        = req_bus.valid && req_bus.ready;

   wpus_scan #(
      .PAGE_BYTES (PAGE_BYTES),
      .MAX_PATTERN(MAX_PATTERN)
   ) u_scan (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .accept   (accept),
      .data_byte(req_bus.data_byte),
      .last_byte(req_bus.last_byte),
      .done     (done),
      .result   (result)
   );

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (done) begin
         rsp_in       = result;
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_ff <= '0;
      end else begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.unique_found = rsp_ff.unique_found;
   assign rsp_bus.match_class  = rsp_ff.match_class;
   assign rsp_bus.hit_address  = rsp_ff.hit_address;

   a_unique_class: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.unique_found == (rsp_ff.match_class == MATCH_ONE)))
      else $error("unique flag disagrees with match class");

   a_addr_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.unique_found) |-> (rsp_ff.hit_address == 16'd0))
      else $error("address set without a unique match");

   a_class_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.match_class != 2'd3))
      else $error("match class out of range");

   a_last_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      (accept && req_bus.last_byte) |=> rsp_valid_ff)
      else $error("page end item produced no result");

endmodule
